FILE: src/msd_pkg.sv
// shared types and constants of the multiplex stream deframer
package msd_pkg;

	// fixed field widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned HDR_W   = 24;
	localparam int unsigned CNT_W   = 48;
	localparam int unsigned CFG_W   = 24;
	localparam int unsigned CFG_IDX_W = 2;

	// header byte counter value at which the channel byte is next
	localparam logic [1:0] HDR_CHAN_NEXT = 2'd3;

	localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

	// reset values of the configuration registers
	localparam logic [BYTE_W-1:0] TAG_OFFSET_RST  = 8'd7;
	localparam logic [HDR_W-1:0]  MAX_OOB_LEN_RST = 24'd1024;

	// channel offsets (from tag_offset) that carry remote errors
	localparam logic [BYTE_W-1:0] ERR_OFS_A = 8'd1;
	localparam logic [BYTE_W-1:0] ERR_OFS_B = 8'd3;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MUX_ENABLE  = 2'd0,
		CFG_TAG_OFFSET  = 2'd1,
		CFG_MAX_OOB_LEN = 2'd2
	} cfg_idx_t;

	// result word kinds
	typedef enum logic [1:0] {
		KIND_STATUS  = 2'd0,
		KIND_DATA    = 2'd1,
		KIND_OOB     = 2'd2,
		KIND_OOB_END = 2'd3
	} kind_t;

	// status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TOO_LONG = 2'd1,
		ST_REMOTE   = 2'd2,
		ST_HALTED   = 2'd3
	} status_t;

	// configuration register contents
	typedef struct packed {
		logic              mux_enable;
		logic [BYTE_W-1:0] tag_offset;
		logic [HDR_W-1:0]  max_oob_len;
	} cfg_t;

	// one result word
	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] byte_value;
		logic [BYTE_W-1:0] channel_code;
		logic              msg_last;
		status_t           status;
		logic [CNT_W-1:0]  data_total;
	} res_t;

	// deframer status toward the top level
	typedef struct packed {
		logic halted;
		logic res_valid;
	} dfr_stat_t;

endpackage

FILE: src/msd_link_if.sv
// channel carrying one received link byte per word
interface msd_link_if;
	logic       valid;
	logic       ready;
	logic [7:0] link_byte;

	modport source (output valid, output link_byte, input ready);
	modport sink (input valid, input link_byte, output ready);
endinterface

FILE: src/msd_result_if.sv
// channel carrying one deframer result per word
interface msd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  byte_value;
	logic [7:0]  channel_code;
	logic        msg_last;
	logic [1:0]  status;
	logic [47:0] data_total;

	modport source (output valid, output kind, output byte_value, output channel_code,
		output msg_last, output status, output data_total, input ready);
	modport sink (input valid, input kind, input byte_value, input channel_code,
		input msg_last, input status, input data_total, output ready);
endinterface

FILE: src/mux_stream_deframer_core.sv
// top level of the multiplex stream deframer
// Receive-side deframer for a byte stream with 4-byte multiplex headers. One
// link byte is taken per cycle, sustained, with either side free to stall. An
// accepted byte is held in the input register until the result register can
// take a word; its result word is then loaded into the result register, which
// offers it. A result word that is held in the result register stalls the
// input register, and through it the link, in the same cycle. The rate is set
// by the message state loop, which updates once per byte. Header bytes and
// empty data messages give no result, except that the channel byte of an empty
// or oversized out-of-band message gives one. Configuration is written through
// cfg_we/cfg_index/cfg_wdata; the user must write it only while the block is
// idle, and the block itself does not enforce this. No clearing pass after
// reset.
module mux_stream_deframer_core #(
	parameter int unsigned LEN_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	msd_link_if.sink                      link_in,
	msd_result_if.source                  result_out,
	input  logic                          cfg_we,
	input  logic [msd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [msd_pkg::CFG_W-1:0]     cfg_wdata
);

	msd_pkg::cfg_t              cfg;
	msd_pkg::res_t              res;
	msd_pkg::dfr_stat_t         stat;
	msd_pkg::res_t              out_q;
	logic                       out_valid_q;
	logic                       valid_s1;
	logic [msd_pkg::BYTE_W-1:0] byte_s1;
	logic                       go;

	// process the registered byte when the result register can take a word
	assign go            = valid_s1 && (!out_valid_q || result_out.ready);
	assign link_in.ready = !valid_s1 || go;

	msd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	msd_deframe #(
		.LEN_BITS (LEN_BITS)
	) u_deframe (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.byte_in (byte_s1),
		.cfg     (cfg),
		.res     (res),
		.stat    (stat)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (link_in.ready) begin
			valid_s1 <= link_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (link_in.ready && link_in.valid) begin
			byte_s1 <= link_in.link_byte;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && stat.res_valid) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && stat.res_valid) begin
			out_q <= res;
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.kind         = out_q.kind;
	assign result_out.byte_value   = out_q.byte_value;
	assign result_out.channel_code = out_q.channel_code;
	assign result_out.msg_last     = out_q.msg_last;
	assign result_out.status       = out_q.status;
	assign result_out.data_total   = out_q.data_total;

`ifndef SYNTHESIS
	// a byte waiting in the input register is held until processed
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !go |=> valid_s1 && $stable(byte_s1))
		else $error("input register lost or changed a pending byte");

	// a too-long or remote-error result leaves the block halted
	assert property (@(posedge clk) disable iff (!arst_n)
		go && stat.res_valid &&
		(res.status == msd_pkg::ST_TOO_LONG || res.status == msd_pkg::ST_REMOTE)
		|=> stat.halted)
		else $error("error status without halt");

	// once halted, every byte yields a halted status word only
	assert property (@(posedge clk) disable iff (!arst_n)
		go && stat.halted |-> stat.res_valid && res.kind == msd_pkg::KIND_STATUS &&
		res.status == msd_pkg::ST_HALTED)
		else $error("halted block produced a non-status word");
`endif

endmodule

FILE: src/msd_cfg.sv
// configuration register file
module msd_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [msd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [msd_pkg::CFG_W-1:0]     cfg_wdata,
	output msd_pkg::cfg_t                 cfg
);

	msd_pkg::cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mux_enable  <= 1'b0;
			cfg_q.tag_offset  <= msd_pkg::TAG_OFFSET_RST;
			cfg_q.max_oob_len <= msd_pkg::MAX_OOB_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				msd_pkg::CFG_MUX_ENABLE:  cfg_q.mux_enable  <= cfg_wdata[0];
				msd_pkg::CFG_TAG_OFFSET:  cfg_q.tag_offset  <= cfg_wdata[msd_pkg::BYTE_W-1:0];
				msd_pkg::CFG_MAX_OOB_LEN: cfg_q.max_oob_len <= cfg_wdata[msd_pkg::HDR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/msd_deframe.sv
// header tracking, message state and result decision for one link byte
module msd_deframe #(
	parameter int unsigned LEN_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [msd_pkg::BYTE_W-1:0] byte_in,
	input  msd_pkg::cfg_t              cfg,
	output msd_pkg::res_t              res,
	output msd_pkg::dfr_stat_t         stat
);

	logic [1:0]                   seen_q, seen_d;
	logic [msd_pkg::HDR_W-1:0]    hdr_q, hdr_d;
	logic [LEN_BITS-1:0]          rem_q, rem_d, rem_dec, len_w;
	logic [msd_pkg::BYTE_W-1:0]   cur_q, cur_d;
	logic                         halted_q, halted_d;
	logic [msd_pkg::CNT_W-1:0]    cnt_q, cnt_d, cnt_inc;
	logic                         res_valid;
	logic                         err_cur, err_new;
	logic [msd_pkg::BYTE_W-1:0]   ofs_cur, ofs_new;

	// helpers: length field, decremented count, saturating counter
	assign len_w   = hdr_q[LEN_BITS-1:0];
	assign rem_dec = rem_q - LEN_BITS'(1);
	assign cnt_inc = (&cnt_q) ? cnt_q : cnt_q + msd_pkg::CNT_W'(1);

	// error channel detection for the current and the incoming channel
	assign ofs_cur = cur_q - cfg.tag_offset;
	assign ofs_new = byte_in - cfg.tag_offset;
	assign err_cur = (ofs_cur == msd_pkg::ERR_OFS_A) || (ofs_cur == msd_pkg::ERR_OFS_B);
	assign err_new = (ofs_new == msd_pkg::ERR_OFS_A) || (ofs_new == msd_pkg::ERR_OFS_B);

	// next state and result for the byte
	always_comb begin
		seen_d    = seen_q;
		hdr_d     = hdr_q;
		rem_d     = rem_q;
		cur_d     = cur_q;
		halted_d  = halted_q;
		cnt_d     = cnt_q;
		res_valid = 1'b0;
		res.kind         = msd_pkg::KIND_STATUS;
		res.byte_value   = '0;
		res.channel_code = cur_q;
		res.msg_last     = 1'b0;
		res.status       = msd_pkg::ST_OK;
		if (halted_q) begin
			res_valid  = 1'b1;
			res.status = msd_pkg::ST_HALTED;
		end else if (!cfg.mux_enable) begin
			cnt_d            = cnt_inc;
			res_valid        = 1'b1;
			res.kind         = msd_pkg::KIND_DATA;
			res.byte_value   = byte_in;
			res.channel_code = '0;
		end else if (rem_q == '0) begin
			if (seen_q != msd_pkg::HDR_CHAN_NEXT) begin
				// gather a length byte
				case (seen_q)
					2'd0:    hdr_d[7:0]   = byte_in;
					2'd1:    hdr_d[15:8]  = byte_in;
					2'd2:    hdr_d[23:16] = byte_in;
					default: ;
				endcase
				seen_d = seen_q + 2'd1;
			end else begin
				// channel byte completes the header
				cur_d            = byte_in;
				hdr_d            = '0;
				seen_d           = '0;
				rem_d            = len_w;
				res.channel_code = byte_in;
				if (byte_in != cfg.tag_offset) begin
					if (msd_pkg::HDR_W'(len_w) > cfg.max_oob_len) begin
						rem_d      = '0;
						halted_d   = 1'b1;
						res_valid  = 1'b1;
						res.status = msd_pkg::ST_TOO_LONG;
					end else if (len_w == '0) begin
						res_valid    = 1'b1;
						res.kind     = msd_pkg::KIND_OOB_END;
						res.msg_last = 1'b1;
						if (err_new) begin
							halted_d   = 1'b1;
							res.status = msd_pkg::ST_REMOTE;
						end
					end
				end
			end
		end else begin
			// payload byte
			rem_d     = rem_dec;
			res_valid = 1'b1;
			if (cur_q == cfg.tag_offset) begin
				cnt_d          = cnt_inc;
				res.kind       = msd_pkg::KIND_DATA;
				res.byte_value = byte_in;
			end else if (rem_dec != '0) begin
				res.kind       = msd_pkg::KIND_OOB;
				res.byte_value = byte_in;
			end else begin
				res.msg_last = 1'b1;
				if (err_cur) begin
					halted_d   = 1'b1;
					res.status = msd_pkg::ST_REMOTE;
				end
				if (byte_in == msd_pkg::NEWLINE) begin
					res.kind = msd_pkg::KIND_OOB_END;
				end else begin
					res.kind       = msd_pkg::KIND_OOB;
					res.byte_value = byte_in;
				end
			end
		end
		res.data_total = cnt_d;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= '0;
			hdr_q    <= '0;
			rem_q    <= '0;
			cur_q    <= '0;
			halted_q <= 1'b0;
			cnt_q    <= '0;
		end else if (go) begin
			seen_q   <= seen_d;
			hdr_q    <= hdr_d;
			rem_q    <= rem_d;
			cur_q    <= cur_d;
			halted_q <= halted_d;
			cnt_q    <= cnt_d;
		end
	end

	assign stat.halted    = halted_q;
	assign stat.res_valid = res_valid;

endmodule
